[hdl/clcd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, command codes and address-map helpers for the character display
// cursor tracker. Used by char_lcd_cursor_wrap; depends on nothing else.
package clcd_pkg;

	localparam int AddrW = 7;
	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);

	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_MOVE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] MODE_ONE = 2'd0;
	localparam logic [1:0] MODE_TWO = 2'd1;
	localparam logic [1:0] MODE_FOUR = 2'd2;
	localparam logic [1:0] MODE_ALIAS_FOUR = 2'd3;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] INSTR_CLEAR = 8'h01;

	typedef struct packed {
		logic bus_valid;
		logic reg_select;
		logic [7:0] bus_byte;
		logic error;
		logic last;
	} result_t;

	function automatic logic at_line_end(input logic [1:0] m, input logic [AddrW-1:0] pos);
		logic r;
		case (m)
			MODE_ONE: r = (pos == 7'h4F);
			MODE_TWO: r = (pos == 7'h27) || (pos == 7'h67);
			default: r = (pos == 7'h13) || (pos == 7'h53) || (pos == 7'h27) || (pos == 7'h67);
		endcase
		return r;
	endfunction

	function automatic logic [1:0] which_line(input logic [1:0] m, input logic [AddrW-1:0] pos);
		logic [1:0] r;
		case (m)
			MODE_ONE: r = 2'd0;
			MODE_TWO: r = (pos <= 7'h27) ? 2'd0 : 2'd1;
			default: begin
				if (pos <= 7'h13) r = 2'd0;
				else if (pos >= 7'h40 && pos <= 7'h53) r = 2'd1;
				else if (pos >= 7'h14 && pos <= 7'h27) r = 2'd2;
				else r = 2'd3;
			end
		endcase
		return r;
	endfunction

	function automatic logic [AddrW-1:0] row_start(input logic [1:0] row);
		logic [AddrW-1:0] r;
		case (row)
			2'd0: r = 7'h00;
			2'd1: r = 7'h40;
			2'd2: r = 7'h14;
			default: r = 7'h54;
		endcase
		return r;
	endfunction

endpackage

[hdl/char_lcd_cursor_wrap.sv]
`timescale 1ns / 1ps
// Cursor tracker for an HD44780-type character display (1, 2 or 4 lines).
// Depends on clcd_pkg for command codes, the result type and the address map.

// Each accepted command beat is captured in an input register, decoded against the
// cursor combinationally, and its one or two result beats are pushed into a four-entry
// result queue that drives the output. A new command can be taken every cycle while the
// queue has room; the command register advances whenever the queue has room for two
// results, so the sustained rate is one command per cycle as long as each yields one
// result and the output is not stalled. A character written at the end of a line
// yields two result beats. Command three yields no result. line_mode resets to
// two-line operation and should only be written while the block is idle.
module char_lcd_cursor_wrap (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic [1:0] row,
	input  logic [6:0] column,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       bus_valid,
	output logic       reg_select,
	output logic [7:0] bus_byte,
	output logic       error,
	output logic       last
);

	localparam int Aw = clcd_pkg::AddrW;
	localparam int Qd = clcd_pkg::QDepth;
	localparam int Qa = clcd_pkg::QAw;

	logic [1:0]    line_mode_q;
	logic [Aw-1:0] cursor_q;

	logic          valid_s1;
	logic [1:0]    cmd_s1;
	logic [7:0]    char_s1;
	logic [1:0]    row_s1;
	logic [6:0]    col_s1;

	clcd_pkg::result_t queue_q [Qd];
	logic [Qa-1:0] head_q, tail_q;
	logic [Qa:0]   count_q;

	logic          adv, pop;
	logic [1:0]    mode;
	logic [2:0]    nlines;
	logic [2:0]    nxt_line;
	logic [Aw-1:0] next_addr, move_addr, cursor_d;
	logic          move_bad;
	logic [1:0]    n_res;
	clcd_pkg::result_t r0, r1;

	// Room for two results is required before a command leaves the input register.
	assign adv      = valid_s1 && (count_q <= (Qa+1)'(Qd - 2));
	assign in_ready = !valid_s1 || adv;
	assign out_valid = (count_q != '0);
	assign pop      = out_valid && out_ready;

	assign mode = (line_mode_q == clcd_pkg::MODE_ALIAS_FOUR) ? clcd_pkg::MODE_FOUR : line_mode_q;

	always_comb begin
		case (mode)
			clcd_pkg::MODE_ONE: nlines = 3'd1;
			clcd_pkg::MODE_TWO: nlines = 3'd2;
			default: nlines = 3'd4;
		endcase
		nxt_line = {1'b0, clcd_pkg::which_line(mode, cursor_q)} + 3'd1;
		if (nxt_line >= nlines) nxt_line = 3'd0;
		next_addr = clcd_pkg::row_start(nxt_line[1:0]);

		case (mode)
			clcd_pkg::MODE_ONE: move_bad = (row_s1 != 2'd0) || (col_s1 > 7'h4F);
			clcd_pkg::MODE_TWO: move_bad = (row_s1 > 2'd1) || (col_s1 > 7'h27);
			default: move_bad = (col_s1 > 7'h13);
		endcase
		move_addr = clcd_pkg::row_start(row_s1) + col_s1;
	end

	always_comb begin
		r0 = '{bus_valid: 1'b1, reg_select: 1'b0, bus_byte: 8'h00, error: 1'b0, last: 1'b1};
		r1 = '{bus_valid: 1'b1, reg_select: 1'b0, bus_byte: {1'b1, next_addr},
			error: 1'b0, last: 1'b1};
		n_res = 2'd1;
		cursor_d = cursor_q;
		case (cmd_s1)
			clcd_pkg::CMD_PUT: begin
				if (char_s1 == clcd_pkg::CHAR_NEWLINE) begin
					r0.bus_byte = {1'b1, next_addr};
					cursor_d = next_addr;
				end else if (clcd_pkg::at_line_end(mode, cursor_q)) begin
					r0.reg_select = 1'b1;
					r0.bus_byte = char_s1;
					r0.last = 1'b0;
					n_res = 2'd2;
					cursor_d = next_addr;
				end else begin
					r0.reg_select = 1'b1;
					r0.bus_byte = char_s1;
					cursor_d = cursor_q + 1'b1;
				end
			end
			clcd_pkg::CMD_MOVE: begin
				if (move_bad) begin
					r0.bus_valid = 1'b0;
					r0.error = 1'b1;
				end else begin
					r0.bus_byte = {1'b1, move_addr};
					cursor_d = move_addr;
				end
			end
			clcd_pkg::CMD_CLEAR: begin
				r0.bus_byte = clcd_pkg::INSTR_CLEAR;
				cursor_d = '0;
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= clcd_pkg::MODE_TWO;
			cursor_q <= '0;
			valid_s1 <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) line_mode_q <= cfg_data;
			if (in_ready) valid_s1 <= in_valid;
			if (adv) begin
				cursor_q <= cursor_d;
				tail_q <= tail_q + Qa'(n_res);
			end
			if (pop) head_q <= head_q + 1'b1;
			count_q <= count_q + (adv ? (Qa+1)'(n_res) : '0) - (Qa+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			char_s1 <= char_code;
			row_s1 <= row;
			col_s1 <= column;
		end
		if (adv && n_res != 2'd0) queue_q[tail_q] <= r0;
		if (adv && n_res == 2'd2) queue_q[tail_q + 1'b1] <= r1;
	end

	assign bus_valid  = queue_q[head_q].bus_valid;
	assign reg_select = queue_q[head_q].reg_select;
	assign bus_byte   = queue_q[head_q].bus_byte;
	assign error      = queue_q[head_q].error;
	assign last       = queue_q[head_q].last;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Qa+1)'(Qd))
		else $error("result queue count exceeds depth");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 == clcd_pkg::CMD_CLEAR) |=> (cursor_q == '0))
		else $error("cursor not zero after clear");

	a_error_no_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (!bus_valid && last))
		else $error("error beat carries a bus transfer");

	a_data_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !reg_select && bus_valid && !last) |-> 1'b0)
		else $error("instruction beat not marked last");
`endif

endmodule

[tb/char_lcd_cursor_wrap_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_cursor_wrap: directed and random display
// commands in every line mode. Depends on clcd_pkg and the char_lcd_cursor_wrap RTL.
module char_lcd_cursor_wrap_test;
	import clcd_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [7:0] INSTR_SET_ADDR = 8'h80;
	localparam logic [27:0] LINE_STARTS = {7'h54, 7'h14, 7'h40, 7'h00};
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [1:0] row_sel;
		logic [6:0] col;
	} cmd_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_data = MODE_TWO;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_PUT;
	logic [7:0] char_code = 8'h00;
	logic [1:0] row = 2'd0;
	logic [6:0] column = 7'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic bus_valid;
	logic reg_select;
	logic [7:0] bus_byte;
	logic error;
	logic last;

	cmd_beat_t pending_cmds[$];
	result_t expected_transfers[$];
	cmd_beat_t drv_beat;
	result_t want;
	logic in_taken = 1'b0;
	logic [1:0] mode_model = MODE_TWO;
	logic [6:0] cursor_model = 7'd0;
	int idle_pct = 11;
	int fail_count = 0;
	int stall_cycles = 0;
	logic [1:0] phase_modes [5] = '{MODE_ONE, MODE_FOUR, MODE_ALIAS_FOUR, MODE_TWO, MODE_ONE};

	char_lcd_cursor_wrap dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.char_code(char_code),
		.row(row),
		.column(column),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bus_valid(bus_valid),
		.reg_select(reg_select),
		.bus_byte(bus_byte),
		.error(error),
		.last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Number of lines and line length; mode three behaves as four lines.
	function automatic void mode_geometry(input logic [1:0] m, output int nlines,
			output int len);
		case (m)
			MODE_ONE: begin
				nlines = 1;
				len = 80;
			end
			MODE_TWO: begin
				nlines = 2;
				len = 40;
			end
			default: begin
				nlines = 4;
				len = 20;
			end
		endcase
	endfunction

	function automatic void predict_transfers(input cmd_beat_t b);
		int nlines;
		int len;
		int lidx;
		int nidx;
		logic [6:0] next_start;
		logic [6:0] target;
		logic at_end;
		mode_geometry(mode_model, nlines, len);
		// Addresses off the visible map still decode to some line.
		if (nlines == 1)
			lidx = 0;
		else if (nlines == 2)
			lidx = (cursor_model > 7'h27) ? 1 : 0;
		else if (cursor_model < 7'h14)
			lidx = 0;
		else if (cursor_model < 7'h28)
			lidx = 2;
		else if (cursor_model >= 7'h40 && cursor_model < 7'h54)
			lidx = 1;
		else
			lidx = 3;
		at_end = (cursor_model == LINE_STARTS[7*lidx +: 7] + len - 1);
		nidx = (lidx + 1 >= nlines) ? 0 : lidx + 1;
		next_start = LINE_STARTS[7*nidx +: 7];
		case (b.op)
			CMD_PUT: begin
				if (b.ch == CHAR_NEWLINE) begin
					expected_transfers.push_back(result_t'{1'b1, 1'b0,
						INSTR_SET_ADDR | next_start, 1'b0, 1'b1});
					cursor_model = next_start;
				end else if (at_end) begin
					expected_transfers.push_back(result_t'{1'b1, 1'b1, b.ch, 1'b0, 1'b0});
					expected_transfers.push_back(result_t'{1'b1, 1'b0,
						INSTR_SET_ADDR | next_start, 1'b0, 1'b1});
					cursor_model = next_start;
				end else begin
					expected_transfers.push_back(result_t'{1'b1, 1'b1, b.ch, 1'b0, 1'b1});
					cursor_model = cursor_model + 7'd1;
				end
			end
			CMD_MOVE: begin
				if (int'(b.row_sel) >= nlines || int'(b.col) >= len) begin
					expected_transfers.push_back(result_t'{1'b0, 1'b0, 8'h00, 1'b1, 1'b1});
				end else begin
					target = LINE_STARTS[7*b.row_sel +: 7] + b.col;
					expected_transfers.push_back(result_t'{1'b1, 1'b0,
						INSTR_SET_ADDR | target, 1'b0, 1'b1});
					cursor_model = target;
				end
			end
			CMD_CLEAR: begin
				expected_transfers.push_back(result_t'{1'b1, 1'b0, INSTR_CLEAR, 1'b0, 1'b1});
				cursor_model = 7'd0;
			end
			default: ;
		endcase
	endfunction

	function automatic cmd_beat_t make_beat(input logic [1:0] op, input logic [7:0] ch,
			input logic [1:0] r, input logic [6:0] c);
		cmd_beat_t b;
		b.op = op;
		b.ch = ch;
		b.row_sel = r;
		b.col = c;
		return b;
	endfunction

	// Mostly text with cursor moves near line ends; some bad moves, clears and
	// the unused command as noise. Unused fields carry random values.
	function automatic cmd_beat_t random_beat(input logic [1:0] m);
		cmd_beat_t b;
		int nlines;
		int len;
		int sel;
		mode_geometry(m, nlines, len);
		b = make_beat(CMD_PUT, 8'($urandom), 2'($urandom), 7'($urandom));
		sel = $urandom_range(99);
		if (sel < 62) begin
			b.op = CMD_PUT;
		end else if (sel < 68) begin
			b.op = CMD_PUT;
			b.ch = CHAR_NEWLINE;
		end else if (sel < 86) begin
			b.op = CMD_MOVE;
			b.row_sel = 2'($urandom_range(nlines - 1));
			if ($urandom_range(1) == 0)
				b.col = 7'($urandom_range(len - 1));
			else
				b.col = 7'(len - 1 - $urandom_range(1));
		end else if (sel < 92) begin
			b.op = CMD_MOVE;
		end else if (sel < 98) begin
			b.op = CMD_CLEAR;
		end else begin
			b.op = CMD_NONE;
		end
		return b;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	// Waits until nothing is queued, in flight or outstanding and then lets the input register
	// empty, since an ignored command leaves no result to wait for.
	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || expected_transfers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_line_mode(input logic [1:0] m);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_taken) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
					drv_beat = pending_cmds.pop_front();
					cmd <= drv_beat.op;
					char_code <= drv_beat.ch;
					row <= drv_beat.row_sel;
					column <= drv_beat.col;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (cfg_we)
				mode_model = cfg_data;
			if (out_valid && out_ready) begin
				if (expected_transfers.size() == 0) begin
					$error("bus beat with no expectation: byte 0x%0h", bus_byte);
					fail_count++;
				end else begin
					want = expected_transfers.pop_front();
					check_field("bus_valid", 8'(want.bus_valid), 8'(bus_valid));
					check_field("reg_select", 8'(want.reg_select), 8'(reg_select));
					check_field("bus_byte", want.bus_byte, bus_byte);
					check_field("error", 8'(want.error), 8'(error));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (in_valid && in_ready)
				predict_transfers(make_beat(cmd, char_code, row, column));
			in_taken <= in_valid && in_ready;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == STALL_LIMIT) begin
			$display("[char_lcd_cursor_wrap] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed beats in the two-line reset mode.
		pending_cmds.push_back(make_beat(CMD_PUT, 8'h00, 2'd3, 7'h7F));
		pending_cmds.push_back(make_beat(CMD_PUT, 8'hFF, 2'd0, 7'h00));
		pending_cmds.push_back(make_beat(CMD_PUT, CHAR_NEWLINE, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'h00, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'h00, 2'd1, 7'd39));
		pending_cmds.push_back(make_beat(CMD_PUT, 8'h5A, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'hFF, 2'd0, 7'd39));
		pending_cmds.push_back(make_beat(CMD_PUT, 8'h41, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_PUT, CHAR_NEWLINE, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'h00, 2'd2, 7'd0));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'h00, 2'd0, 7'd40));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'h00, 2'd3, 7'd127));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'h00, 2'd1, 7'd0));
		pending_cmds.push_back(make_beat(CMD_NONE, 8'hA5, 2'd2, 7'h55));
		pending_cmds.push_back(make_beat(CMD_CLEAR, 8'h00, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_PUT, 8'h80, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_MOVE, 8'h00, 2'd1, 7'd39));
		pending_cmds.push_back(make_beat(CMD_PUT, CHAR_NEWLINE, 2'd0, 7'd0));
		pending_cmds.push_back(make_beat(CMD_PUT, CHAR_NEWLINE, 2'd0, 7'd0));

		// Random phases; the cursor carries over from one mode into the next, so a new mode can start off its map.
		for (int p = 0; p < 5; p++) begin
			set_line_mode(phase_modes[p]);
			idle_pct = (p == 2) ? 0 : 11;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_cmds.push_back(random_beat(phase_modes[p]));
		end
		drain();
		if (fail_count == 0)
			$display("[char_lcd_cursor_wrap] OK");
		else
			$display("[char_lcd_cursor_wrap] ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/clcd_pkg.sv
hdl/char_lcd_cursor_wrap.sv
tb/char_lcd_cursor_wrap_test.sv
